FILE: rtl/core/csv_pkg.sv
// Shared types, widths and lane codes for the crossed-string coefficient block.
`default_nettype none

package csv_pkg;

    // Coordinate width of one input field (two's complement Q15.16 at 32 bits).
    localparam int COORD_W = 32;

    // Number of endpoint distances formed per segment pair.
    localparam int NLANE = 4;

    // Magnitude of one coordinate difference, split in two halves for squaring.
    localparam int MAG_W = COORD_W + 1;
    localparam int LO_W  = (MAG_W + 1) / 2;
    localparam int HI_W  = MAG_W - LO_W;

    // Square of one difference and sum of two squares.
    localparam int SQ_W  = 2 * MAG_W;
    localparam int RAD_W = SQ_W + 1;

    // Integer square root: one result bit per pipeline stage.
    localparam int ROOT_W = COORD_W + 2;
    localparam int RAD2_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Sum of two distances and the coefficient output.
    localparam int SUM_W   = ROOT_W + 1;
    localparam int COEFF_W = 34;
    localparam int CMP_W   = (SUM_W > COEFF_W) ? SUM_W : COEFF_W;

    localparam logic [COEFF_W-1:0] COEFF_MAX = '1;

    // Lane assignment of the four endpoint distances.
    localparam int LANE_R12 = 0;  // A start to B start
    localparam int LANE_R21 = 1;  // A end to B end
    localparam int LANE_R22 = 2;  // A end to B start
    localparam int LANE_R11 = 3;  // A start to B end

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [RAD_W-1:0]          rad_t;
    typedef logic [ROOT_W-1:0]         root_t;
    typedef logic [COEFF_W-1:0]        coeff_t;

    // One segment pair.
    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_end_x;
        coord_t b_end_y;
    } in_item_t;

    // One coefficient result.
    typedef struct packed {
        coeff_t coefficient;
        logic   below_threshold;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/csv_front.sv
// Endpoint differences, squares and squared distances for the four lanes.
`default_nettype none

module csv_front (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire csv_pkg::in_item_t                      in_data,
    output logic                                        out_valid,
    output csv_pkg::rad_t [csv_pkg::NLANE-1:0]          rad
);

    localparam int NVAL = 2 * csv_pkg::NLANE;
    localparam int HH_W = 2 * csv_pkg::HI_W;
    localparam int HL_W = csv_pkg::HI_W + csv_pkg::LO_W;
    localparam int LL_W = 2 * csv_pkg::LO_W;

    // Magnitude of a - b; it needs one bit more than a coordinate.
    function automatic logic [csv_pkg::MAG_W-1:0] abs_diff(input csv_pkg::coord_t a,
                                                           input csv_pkg::coord_t b);
        logic signed [csv_pkg::COORD_W:0] ae;
        logic signed [csv_pkg::COORD_W:0] be;
        ae = {a[csv_pkg::COORD_W-1], a};
        be = {b[csv_pkg::COORD_W-1], b};
        if (a >= b) begin
            return csv_pkg::MAG_W'(ae - be);
        end else begin
            return csv_pkg::MAG_W'(be - ae);
        end
    endfunction

    csv_pkg::coord_t px [csv_pkg::NLANE];
    csv_pkg::coord_t py [csv_pkg::NLANE];
    csv_pkg::coord_t qx [csv_pkg::NLANE];
    csv_pkg::coord_t qy [csv_pkg::NLANE];

    logic [csv_pkg::MAG_W-1:0] mag_next [NVAL];
    logic [csv_pkg::MAG_W-1:0] mag_reg  [NVAL];
    logic [HH_W-1:0]           hh_next  [NVAL];
    logic [HH_W-1:0]           hh_reg   [NVAL];
    logic [HL_W-1:0]           hl_next  [NVAL];
    logic [HL_W-1:0]           hl_reg   [NVAL];
    logic [LL_W-1:0]           ll_next  [NVAL];
    logic [LL_W-1:0]           ll_reg   [NVAL];
    logic [csv_pkg::SQ_W-1:0]  sq_next  [NVAL];
    logic [csv_pkg::SQ_W-1:0]  sq_reg   [NVAL];
    csv_pkg::rad_t             rad_next [csv_pkg::NLANE];
    csv_pkg::rad_t             rad_reg  [csv_pkg::NLANE];
    logic [3:0]                vld_reg;

    // Endpoint pairs of the four distances.
    always_comb begin
        px[csv_pkg::LANE_R12] = in_data.a_start_x;
        py[csv_pkg::LANE_R12] = in_data.a_start_y;
        qx[csv_pkg::LANE_R12] = in_data.b_start_x;
        qy[csv_pkg::LANE_R12] = in_data.b_start_y;
        px[csv_pkg::LANE_R21] = in_data.a_end_x;
        py[csv_pkg::LANE_R21] = in_data.a_end_y;
        qx[csv_pkg::LANE_R21] = in_data.b_end_x;
        qy[csv_pkg::LANE_R21] = in_data.b_end_y;
        px[csv_pkg::LANE_R22] = in_data.a_end_x;
        py[csv_pkg::LANE_R22] = in_data.a_end_y;
        qx[csv_pkg::LANE_R22] = in_data.b_start_x;
        qy[csv_pkg::LANE_R22] = in_data.b_start_y;
        px[csv_pkg::LANE_R11] = in_data.a_start_x;
        py[csv_pkg::LANE_R11] = in_data.a_start_y;
        qx[csv_pkg::LANE_R11] = in_data.b_end_x;
        qy[csv_pkg::LANE_R11] = in_data.b_end_y;
    end

    // Stage 1: absolute differences; even slots hold dx, odd slots dy.
    always_comb begin
        for (int l = 0; l < csv_pkg::NLANE; l++) begin
            mag_next[2*l]   = abs_diff(px[l], qx[l]);
            mag_next[2*l+1] = abs_diff(py[l], qy[l]);
        end
    end

    // Stage 2: partial products of each square from its high and low halves.
    always_comb begin
        for (int k = 0; k < NVAL; k++) begin
            hh_next[k] = HH_W'(mag_reg[k][csv_pkg::MAG_W-1:csv_pkg::LO_W])
                       * HH_W'(mag_reg[k][csv_pkg::MAG_W-1:csv_pkg::LO_W]);
            hl_next[k] = HL_W'(mag_reg[k][csv_pkg::MAG_W-1:csv_pkg::LO_W])
                       * HL_W'(mag_reg[k][csv_pkg::LO_W-1:0]);
            ll_next[k] = LL_W'(mag_reg[k][csv_pkg::LO_W-1:0])
                       * LL_W'(mag_reg[k][csv_pkg::LO_W-1:0]);
        end
    end

    // Stage 3: full squares; the cross term appears twice, hence one extra shift.
    always_comb begin
        for (int k = 0; k < NVAL; k++) begin
            sq_next[k] = (csv_pkg::SQ_W'(hh_reg[k]) << (2 * csv_pkg::LO_W))
                       + (csv_pkg::SQ_W'(hl_reg[k]) << (csv_pkg::LO_W + 1))
                       + csv_pkg::SQ_W'(ll_reg[k]);
        end
    end

    // Stage 4: squared distance of each lane.
    always_comb begin
        for (int l = 0; l < csv_pkg::NLANE; l++) begin
            rad_next[l] = csv_pkg::RAD_W'(sq_reg[2*l]) + csv_pkg::RAD_W'(sq_reg[2*l+1]);
        end
    end

    // Pipeline registers advance together whenever the output side has room.
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
            hh_reg  <= hh_next;
            hl_reg  <= hl_next;
            ll_reg  <= ll_next;
            sq_reg  <= sq_next;
            rad_reg <= rad_next;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_comb begin
        for (int l = 0; l < csv_pkg::NLANE; l++) begin
            rad[l] = rad_reg[l];
        end
    end

    assign out_valid = vld_reg[3];

endmodule

`default_nettype wire

FILE: rtl/core/csv_isqrt.sv
// Pipelined floor integer square root, one result bit per stage, four lanes.
`default_nettype none

module csv_isqrt (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire csv_pkg::rad_t [csv_pkg::NLANE-1:0]     rad,
    output logic                                        out_valid,
    output csv_pkg::root_t [csv_pkg::NLANE-1:0]         root
);

    localparam int NSTG = csv_pkg::ROOT_W;

    typedef struct packed {
        logic [csv_pkg::ROOT_W-1:0] root;
        logic [csv_pkg::REM_W-1:0]  rem;
        logic [csv_pkg::RAD2_W-1:0] n;
    } step_t;

    // One restoring step: bring down two radicand bits, try the next root bit.
    function automatic step_t sqrt_step(input step_t cur);
        step_t                     nxt;
        logic [csv_pkg::REM_W-1:0] rem_sh;
        logic [csv_pkg::REM_W-1:0] trial;
        rem_sh = {cur.rem[csv_pkg::REM_W-3:0], cur.n[csv_pkg::RAD2_W-1 -: 2]};
        trial  = {cur.root, 2'b01};
        nxt.n  = {cur.n[csv_pkg::RAD2_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            nxt.rem  = rem_sh - trial;
            nxt.root = {cur.root[csv_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = rem_sh;
            nxt.root = {cur.root[csv_pkg::ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    step_t      st_next [NSTG][csv_pkg::NLANE];
    step_t      st_reg  [NSTG][csv_pkg::NLANE];
    logic [NSTG-1:0] vld_reg;

    // Each stage works on the item the previous stage handed over.
    always_comb begin
        step_t seed;
        for (int l = 0; l < csv_pkg::NLANE; l++) begin
            seed.root = '0;
            seed.rem  = '0;
            seed.n    = csv_pkg::RAD2_W'(rad[l]);
            st_next[0][l] = sqrt_step(seed);
            for (int s = 1; s < NSTG; s++) begin
                st_next[s][l] = sqrt_step(st_reg[s-1][l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    // Valid bits follow the items stage by stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_comb begin
        for (int l = 0; l < csv_pkg::NLANE; l++) begin
            root[l] = st_reg[NSTG-1][l].root;
        end
    end

    assign out_valid = vld_reg[NSTG-1];

endmodule

`default_nettype wire

FILE: rtl/core/csv_combine.sv
// Distance sums, signed difference, threshold test and saturation.
`default_nettype none

module csv_combine (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire csv_pkg::root_t [csv_pkg::NLANE-1:0]    root,
    input  wire csv_pkg::coeff_t                        min_coeff,
    output logic                                        out_valid,
    output csv_pkg::out_item_t                          out_data
);

    logic [csv_pkg::SUM_W-1:0] plus_next;
    logic [csv_pkg::SUM_W-1:0] plus_reg;
    logic [csv_pkg::SUM_W-1:0] minus_next;
    logic [csv_pkg::SUM_W-1:0] minus_reg;
    logic [csv_pkg::SUM_W-1:0] diff_next;
    logic [csv_pkg::SUM_W-1:0] diff_reg;
    logic                      neg_next;
    logic                      neg_reg;
    logic [csv_pkg::CMP_W-1:0] diff_ext;
    logic                      below;
    csv_pkg::out_item_t        out_next;
    csv_pkg::out_item_t        out_reg;
    logic [2:0]                vld_reg;

    // Uncrossed and crossed string sums.
    assign plus_next  = csv_pkg::SUM_W'(root[csv_pkg::LANE_R12])
                      + csv_pkg::SUM_W'(root[csv_pkg::LANE_R21]);
    assign minus_next = csv_pkg::SUM_W'(root[csv_pkg::LANE_R22])
                      + csv_pkg::SUM_W'(root[csv_pkg::LANE_R11]);

    // Difference and its sign.
    assign neg_next  = plus_reg < minus_reg;
    assign diff_next = plus_reg - minus_reg;

    // A negative value or one under the threshold becomes zero and is flagged.
    assign diff_ext = csv_pkg::CMP_W'(diff_reg);
    assign below    = neg_reg || (diff_ext < csv_pkg::CMP_W'(min_coeff));

    always_comb begin
        out_next.below_threshold = below;
        if (below) begin
            out_next.coefficient = '0;
        end else if (diff_ext > csv_pkg::CMP_W'(csv_pkg::COEFF_MAX)) begin
            out_next.coefficient = csv_pkg::COEFF_MAX;
        end else begin
            out_next.coefficient = csv_pkg::COEFF_W'(diff_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plus_reg  <= plus_next;
            minus_reg <= minus_next;
            diff_reg  <= diff_next;
            neg_reg   <= neg_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/csv_skid.sv
// Output register with a skid entry that takes one more result when the output stalls.
`default_nettype none

module csv_skid (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire csv_pkg::out_item_t  in_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output csv_pkg::out_item_t       m_data
);

    logic               main_vld_reg;
    logic               main_vld_next;
    csv_pkg::out_item_t main_reg;
    csv_pkg::out_item_t main_next;
    logic               skid_vld_reg;
    logic               skid_vld_next;
    csv_pkg::out_item_t skid_reg;
    csv_pkg::out_item_t skid_next;
    logic               push;
    logic               pop;

    // Ready depends only on a register, never on the downstream ready.
    assign in_ready = !skid_vld_reg;
    assign push     = in_valid && in_ready;
    assign pop      = main_vld_reg && m_ready;

    // The skid entry refills the output first; new results land where there is room.
    always_comb begin
        main_vld_next = main_vld_reg;
        main_next     = main_reg;
        skid_vld_next = skid_vld_reg;
        skid_next     = skid_reg;
        if (skid_vld_reg) begin
            if (pop) begin
                main_next     = skid_reg;
                skid_vld_next = 1'b0;
            end
        end else if (push) begin
            if (!main_vld_reg || pop) begin
                main_next     = in_data;
                main_vld_next = 1'b1;
            end else begin
                skid_next     = in_data;
                skid_vld_next = 1'b1;
            end
        end else if (pop) begin
            main_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            main_vld_reg <= main_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_valid = main_vld_reg;
    assign m_data  = main_reg;

endmodule

`default_nettype wire

FILE: rtl/core/crossed_string_view_coefficient_top.sv
// Top level of the crossed-string view coefficient pipeline.
//
//  Channel   Ports                      Direction  Content
//  -------   -------------------------  ---------  ------------------------------------
//  input     s_valid s_ready s_data     in         two segments, eight Q15.16 coordinates
//  result    m_valid m_ready m_data     out        coefficient (Q.16) and below_threshold
//  config    cfg_valid cfg_ready cfg_data  in      min_coeff threshold, always ready
//
//  One segment pair is taken per cycle while s_ready is high. An input transfer reaches
//  m_valid through 4 front stages, one square-root stage per result bit, 3 combine
//  stages and the output register.
//  Reset is synchronous, active low, clears all valid bits and sets min_coeff to zero.
//  A stalled output holds its result; the skid entry takes one more, then s_ready drops
//  and the whole pipeline freezes in place until the output drains.
`default_nettype none

module crossed_string_view_coefficient_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire csv_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output csv_pkg::out_item_t       m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire csv_pkg::coeff_t     cfg_data
);

    logic                                 en;
    logic                                 front_vld;
    csv_pkg::rad_t  [csv_pkg::NLANE-1:0]  rad;
    logic                                 root_vld;
    csv_pkg::root_t [csv_pkg::NLANE-1:0]  root;
    logic                                 comb_vld;
    csv_pkg::out_item_t                   comb_data;
    csv_pkg::coeff_t                      min_coeff_reg;

    // Threshold register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_coeff_reg <= '0;
        end else if (cfg_valid) begin
            min_coeff_reg <= cfg_data;
        end
    end

    // All pipeline stages advance while the output buffer has room.
    assign s_ready = en;

    csv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (front_vld),
        .rad       (rad)
    );

    csv_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_vld),
        .rad       (rad),
        .out_valid (root_vld),
        .root      (root)
    );

    csv_combine u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (root_vld),
        .root      (root),
        .min_coeff (min_coeff_reg),
        .out_valid (comb_vld),
        .out_data  (comb_data)
    );

    csv_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (comb_vld),
        .in_ready (en),
        .in_data  (comb_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
